// ----- hdl/ist_pkg.sv -----
// Shared types for the interpolation search table: item kinds, the queued
// item record and the search engine states. No dependencies.
package ist_pkg;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  idx;
    logic [15:0] key;
    logic [6:0]  grade;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_POS,
    S_CMP
  } state_t;

endpackage

// ----- hdl/ist_front.sv -----
// Front end: accepts items, drops loads beyond the table, holds the entry
// count register and queues items for the search engine. Uses ist_pkg.
module ist_front #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [3:0]        in_entry_index,
  input  logic [15:0]       in_record_key,
  input  logic [6:0]        in_record_grade,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_entries_in_use,
  output logic              q_valid,
  output ist_pkg::item_t    q_item,
  input  logic              q_pop,
  output logic [IDX_W-1:0]  hi_init
);
  import ist_pkg::*;

  logic [4:0] n_r;
  item_t      slot_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       accept, push, load_ok;
  item_t      in_item;
  int         n_eff;

  assign cfg_ready = 1'b1;
  assign busy      = (cnt_r == 2'd2);
  assign accept    = start && !busy;
  assign load_ok   = (32'(in_entry_index) < TABLE_DEPTH);
  // Loads outside the table leave no trace, so they are not queued.
  assign push      = accept && (in_opcode == 1'b1 || load_ok);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    in_item.op    = in_opcode ? OP_SEARCH : OP_LOAD;
    in_item.idx   = in_entry_index;
    in_item.key   = in_record_key;
    in_item.grade = in_record_grade;
  end

  always_comb begin
    n_eff = int'(n_r);
    if (n_eff == 0) begin
      n_eff = 1;
    end else if (n_eff > TABLE_DEPTH) begin
      n_eff = TABLE_DEPTH;
    end
    hi_init = IDX_W'(n_eff - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= 5'd16;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_r <= cfg_entries_in_use;
      end
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ----- hdl/ist_back.sv -----
// Search engine: owns the key and grade memories, performs loads and runs
// interpolation search with a multiplier and a bit-serial divider. Uses ist_pkg.
module ist_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ist_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic [IDX_W-1:0] hi_init,
  output logic             out_valid,
  output logic             out_found,
  output logic [3:0]       out_position,
  output logic [6:0]       out_grade_out
);
  import ist_pkg::*;

  localparam int PW = 16 + IDX_W;
  localparam int CW = $clog2(PW + 1);

  logic [15:0]      key_mem   [TABLE_DEPTH];
  logic [6:0]       grade_mem [TABLE_DEPTH];
  logic [15:0]      rd_key_r;
  logic [6:0]       rd_grade_r;
  logic [IDX_W-1:0] addr;
  logic             we;

  state_t           state_r, state_nxt;
  logic [IDX_W:0]   lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt, pos_r, pos_nxt, rng_r, rng_nxt;
  logic [15:0]      key_r, key_nxt, klo_r, klo_nxt, diff_r, diff_nxt;
  logic [15:0]      span_r, span_nxt, rem_r, rem_nxt;
  logic [6:0]       glo_r, glo_nxt;
  logic [PW-1:0]    dvd_r, dvd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt, of_r, of_nxt;
  logic [3:0]       op_r, op_nxt;
  logic [6:0]       og_r, og_nxt;
  logic [16:0]      rem_sh;
  logic [PW:0]      pos_sum;
  logic [IDX_W:0]   next_lo;

  assign out_valid     = ov_r;
  assign out_found     = of_r;
  assign out_position  = op_r;
  assign out_grade_out = og_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[IDX_W'(q_item.idx)]   <= q_item.key;
      grade_mem[IDX_W'(q_item.idx)] <= q_item.grade;
    end
    rd_key_r   <= key_mem[addr];
    rd_grade_r <= grade_mem[addr];
  end

  assign rem_sh  = {rem_r, dvd_r[PW-1]};
  assign pos_sum = (PW+1)'(lo_r) + {1'b0, dvd_r};
  assign next_lo = {1'b0, pos_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    lo_nxt = lo_r; hi_nxt = hi_r; pos_nxt = pos_r; rng_nxt = rng_r;
    key_nxt = key_r; klo_nxt = klo_r; diff_nxt = diff_r; span_nxt = span_r;
    rem_nxt = rem_r; glo_nxt = glo_r; dvd_nxt = dvd_r; cnt_nxt = cnt_r;
    ov_nxt = 1'b0; of_nxt = of_r; op_nxt = op_r; og_nxt = og_r;
    q_pop = 1'b0;
    we    = 1'b0;
    addr  = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_LOAD) begin
            we = 1'b1;
          end else begin
            key_nxt   = q_item.key;
            lo_nxt    = '0;
            hi_nxt    = hi_init;
            state_nxt = S_RD_LO;
          end
        end
      end
      S_RD_LO: begin
        addr      = lo_r[IDX_W-1:0];
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        addr      = hi_r;
        klo_nxt   = rd_key_r;
        glo_nxt   = rd_grade_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        diff_nxt = key_r - klo_r;
        span_nxt = rd_key_r - klo_r;
        rng_nxt  = hi_r - lo_r[IDX_W-1:0];
        if (key_r < klo_r || key_r > rd_key_r) begin
          ov_nxt = 1'b1; of_nxt = 1'b0; op_nxt = '0; og_nxt = '0;
          state_nxt = S_IDLE;
        end else if (lo_r[IDX_W-1:0] == hi_r) begin
          ov_nxt = 1'b1;
          of_nxt = (klo_r == key_r);
          op_nxt = (klo_r == key_r) ? 4'(lo_r) : 4'd0;
          og_nxt = (klo_r == key_r) ? glo_r : 7'd0;
          state_nxt = S_IDLE;
        end else if (rd_key_r == klo_r) begin
          ov_nxt = 1'b1; of_nxt = 1'b1; op_nxt = 4'(lo_r); og_nxt = glo_r;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        dvd_nxt   = PW'(diff_r * rng_r);
        rem_nxt   = '0;
        cnt_nxt   = CW'(PW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, span_r}) begin
          rem_nxt = 16'(rem_sh - {1'b0, span_r});
          dvd_nxt = {dvd_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[15:0];
          dvd_nxt = {dvd_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        pos_nxt   = (pos_sum > (PW+1)'(hi_r)) ? hi_r : pos_sum[IDX_W-1:0];
        addr      = pos_nxt;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_key_r == key_r) begin
          ov_nxt = 1'b1; of_nxt = 1'b1; op_nxt = 4'(pos_r); og_nxt = rd_grade_r;
          state_nxt = S_IDLE;
        end else if (rd_key_r < key_r) begin
          lo_nxt = next_lo;
          if (next_lo > {1'b0, hi_r}) begin
            ov_nxt = 1'b1; of_nxt = 1'b0; op_nxt = '0; og_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_LO;
          end
        end else begin
          hi_nxt = pos_r - 1'b1;
          if (pos_r == '0 || {1'b0, pos_r - 1'b1} < lo_r) begin
            ov_nxt = 1'b1; of_nxt = 1'b0; op_nxt = '0; og_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_LO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; pos_r <= pos_nxt; rng_r <= rng_nxt;
    key_r <= key_nxt; klo_r <= klo_nxt; diff_r <= diff_nxt; span_r <= span_nxt;
    rem_r <= rem_nxt; glo_r <= glo_nxt; dvd_r <= dvd_nxt; cnt_r <= cnt_nxt;
    of_r <= of_nxt; op_r <= op_nxt; og_r <= og_nxt;
  end

endmodule

// ----- hdl/interpolation_search_table.sv -----
// Top level of the interpolation search table: front end and search engine.
// Depends on ist_pkg, ist_front and ist_back.
//
// The block keeps a table of TABLE_DEPTH records (16-bit key, 7-bit grade)
// and searches it by interpolation; the user must load the records in
// ascending key order, which the block itself does not enforce. An item is
// taken when start is high and busy is low. A load item (opcode 0) writes one
// entry and produces no result; a search item (opcode 1) produces exactly one
// result, shown for one cycle with out_valid high. The receiver cannot stall,
// so the result must be captured in that cycle. Items pass through a two-deep
// queue, so up to two items are taken while the engine works. A search pops
// the item, reads and checks the bounds, then for each probe multiplies and
// runs the one-bit-per-cycle divider over the 16 + log2(TABLE_DEPTH) bit
// product, and rereads and rechecks the narrowed bounds before each further
// probe; the result appears in the cycle after the final check. A typical
// search of a 16-entry table with evenly spread keys takes one or two probes.
// Every table read goes through a single registered memory read port. Entries
// must be loaded before a search reaches them. Write entries_in_use only while
// the block is idle.
module interpolation_search_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [3:0]  in_entry_index,
  input  logic [15:0] in_record_key,
  input  logic [6:0]  in_record_grade,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_entries_in_use,
  output logic        out_valid,
  output logic        out_found,
  output logic [3:0]  out_position,
  output logic [6:0]  out_grade_out
);
  import ist_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic             q_valid, q_pop;
  item_t            q_item;
  logic [IDX_W-1:0] hi_init;

  // The front end holds the entry count and queues items in arrival order.
  ist_front #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_entry_index, .in_record_key, .in_record_grade,
    .cfg_valid, .cfg_ready, .cfg_entries_in_use,
    .q_valid, .q_item, .q_pop, .hi_init
  );

  // The engine performs loads and searches one at a time.
  ist_back #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .hi_init,
    .out_valid, .out_found, .out_position, .out_grade_out
  );

endmodule
